[rtl/trpr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// trpr_pkg
// Shared types and constants of the tile rotation pixel remap unit.
// ----------------------------------------------------------------------------
package trpr_pkg;

	// fixed field widths
	localparam int FUNC_W    = 1;
	localparam int MAP_IDX_W = 14;
	localparam int DIR_W     = 2;
	localparam int PIXEL_W   = 32;
	localparam int ADDR_W    = 22;

	// configuration port
	localparam int CUBE_W     = 3;
	localparam int DIM_W      = 12;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = DIM_W;

	// register reset values
	localparam int CUBE_BITS_RST    = 4;
	localparam int FRAME_WIDTH_RST  = 640;
	localparam int FRAME_HEIGHT_RST = 480;

	// frame height limit (fixed, sets the row counter width)
	localparam int MAX_HEIGHT = 2048;

	// parameter defaults
	localparam int MAX_WIDTH_DEF     = 2048;
	localparam int MAX_TILES_DEF     = 16384;
	localparam int TILE_LOG2_MAX_DEF = 5;

	// beat function
	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_PIXEL = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CUBE_BITS    = 2'd0,
		REG_FRAME_WIDTH  = 2'd1,
		REG_FRAME_HEIGHT = 2'd2
	} cfg_reg_t;

	typedef enum logic [DIR_W-1:0] {
		DIR_UP    = 2'd0,
		DIR_RIGHT = 2'd1,
		DIR_DOWN  = 2'd2,
		DIR_LEFT  = 2'd3
	} dir_t;

endpackage
`default_nettype wire

[rtl/trpr_in_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// trpr_in_if
// Input stream: map load beats and raster-order pixel beats.
// ----------------------------------------------------------------------------
interface trpr_in_if;
	import trpr_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [FUNC_W-1:0]    func;
	logic [MAP_IDX_W-1:0] map_index;
	logic [DIR_W-1:0]     direction;
	logic [PIXEL_W-1:0]   pixel;

	modport source (
		output valid, func, map_index, direction, pixel,
		input  ready
	);
	modport sink (
		input  valid, func, map_index, direction, pixel,
		output ready
	);
endinterface
`default_nettype wire

[rtl/trpr_out_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// trpr_out_if
// Output stream: remapped pixel with its destination address.
// ----------------------------------------------------------------------------
interface trpr_out_if;
	import trpr_pkg::*;

	logic               valid;
	logic               ready;
	logic [ADDR_W-1:0]  dest_address;
	logic [PIXEL_W-1:0] pixel_value;

	modport source (
		output valid, dest_address, pixel_value,
		input  ready
	);
	modport sink (
		input  valid, dest_address, pixel_value,
		output ready
	);
endinterface
`default_nettype wire

[rtl/tile_rotation_pixel_remap_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tile_rotation_pixel_remap_unit
// Rotates square tiles of a raster pixel stream by a per-tile direction.
// ----------------------------------------------------------------------------
// Usage:
//   pixels carries two kinds of beat. func = 0 loads one entry of the
//   direction map (map_index, direction); func = 1 is the next pixel of the
//   frame in raster order. results carries each remapped pixel with its
//   address in the output frame. Pixels in partial tiles at the right or
//   bottom edge, or in tiles past the map depth, give no result beat.
//   Throughput is one beat per cycle on both sides while results is ready. An
//   accepted pixel passes the map read, tile position, then the row * width
//   multiply into the output register. A load takes effect at its own accept
//   edge, so the very next pixel already sees it. Entries of the map that were
//   never loaded read as unknown. When results stalls, the output register and
//   the two stages behind it hold one pixel each; pixels.ready drops once all
//   three are full. Reset clears the column and row counters, the stage valid
//   bits and sets cube_bits 4, frame_width 640, frame_height 480; the map is
//   not cleared. Configuration (cfg_we, cfg_index, cfg_wdata) is for the user
//   to write only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module tile_rotation_pixel_remap_unit #(
	parameter int MAX_WIDTH     = trpr_pkg::MAX_WIDTH_DEF,
	parameter int MAX_TILES     = trpr_pkg::MAX_TILES_DEF,
	parameter int TILE_LOG2_MAX = trpr_pkg::TILE_LOG2_MAX_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [trpr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [trpr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	trpr_in_if.sink                               pixels,
	trpr_out_if.source                            results
);
	import trpr_pkg::*;

	localparam int CBW = $clog2(TILE_LOG2_MAX + 1);  // effective cube_bits
	localparam int OW  = TILE_LOG2_MAX;              // offset inside a tile
	localparam int CW  = $clog2(MAX_WIDTH);          // column
	localparam int WW  = CW + 1;                     // width value
	localparam int RW  = $clog2(MAX_HEIGHT);         // row
	localparam int HW  = RW + 1;                     // height value
	localparam int TW  = $clog2(MAX_TILES);          // map address
	localparam int TPW = RW + WW + 1;                // full tile number
	localparam int PW  = RW + WW + 1;                // address sum

	localparam int CB_RST = (CUBE_BITS_RST > TILE_LOG2_MAX) ? TILE_LOG2_MAX
		: CUBE_BITS_RST;
	localparam int W_RST  = (FRAME_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH
		: FRAME_WIDTH_RST;
	localparam int H_RST  = (FRAME_HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT
		: FRAME_HEIGHT_RST;

	// configuration, held as clamped values
	logic [CBW-1:0] cb_q;
	logic [WW-1:0]  w_q;
	logic [HW-1:0]  h_q;
	logic [CUBE_W-1:0] cfg_cube;
	logic [DIM_W-1:0]  cfg_dim;
	logic [CBW-1:0]    cb_new;
	logic [WW-1:0]     w_new;
	logic [HW-1:0]     h_new;

	// raster counters
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [CW:0]   col_inc;
	logic [RW:0]   row_inc;

	// stage enables
	logic en_out, en_s2, en_s1;
	logic acc_pix, acc_load;

	// accept stage decode
	logic [OW-1:0]  smask;
	logic [CW-1:0]  mx;
	logic [RW-1:0]  my;
	logic [WW-1:0]  mw;
	logic [HW-1:0]  mh;
	logic [TPW-1:0] tile_full;
	logic           hit;

	// direction map
	logic [DIR_W-1:0] dir_mem [MAX_TILES];

	// stage 1: map data returns
	logic               v_s1;
	logic [PIXEL_W-1:0] pix_s1;
	logic [DIR_W-1:0]   dir_s1;
	logic [OW-1:0]      dx_s1, dy_s1;
	logic [CW-1:0]      tx_s1;
	logic [RW-1:0]      ty_s1;
	logic [OW-1:0]      ox, oy;

	// stage 2: rotated position
	logic               v_s2;
	logic [PIXEL_W-1:0] pix_s2;
	logic [CW-1:0]      col_s2;
	logic [RW-1:0]      row_s2;

	// output register
	logic               out_v_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [PIXEL_W-1:0] pix_q;
	logic [PW-1:0]      addr_sum;

	// ---- configuration write ----
	assign cfg_cube = cfg_wdata[CUBE_W-1:0];
	assign cfg_dim  = cfg_wdata[DIM_W-1:0];

	always_comb begin
		if (int'(cfg_cube) > TILE_LOG2_MAX)
			cb_new = CBW'(TILE_LOG2_MAX);
		else
			cb_new = CBW'(cfg_cube);
		if (cfg_dim == '0)
			w_new = WW'(1);
		else if (int'(cfg_dim) > MAX_WIDTH)
			w_new = WW'(MAX_WIDTH);
		else
			w_new = WW'(cfg_dim);
		if (cfg_dim == '0)
			h_new = HW'(1);
		else if (int'(cfg_dim) > MAX_HEIGHT)
			h_new = HW'(MAX_HEIGHT);
		else
			h_new = HW'(cfg_dim);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cb_q <= CBW'(CB_RST);
			w_q  <= WW'(W_RST);
			h_q  <= HW'(H_RST);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CUBE_BITS:    cb_q <= cb_new;
				REG_FRAME_WIDTH:  w_q  <= w_new;
				REG_FRAME_HEIGHT: h_q  <= h_new;
				default: ;
			endcase
		end
	end

	// ---- handshake: each stage moves when the next one frees up ----
	assign en_out = !out_v_q || results.ready;
	assign en_s2  = !v_s2 || en_out;
	assign en_s1  = !v_s1 || en_s2;
	assign pixels.ready = en_s1;
	assign acc_pix  = pixels.valid && en_s1 && (pixels.func == FUNC_PIXEL);
	assign acc_load = pixels.valid && en_s1 && (pixels.func == FUNC_LOAD);

	// ---- tile lookup from the counters ----
	always_comb begin
		smask     = OW'(((OW + 1)'(1) << cb_q) - (OW + 1)'(1));
		mx        = col_q >> cb_q;
		my        = row_q >> cb_q;
		mw        = w_q >> cb_q;
		mh        = h_q >> cb_q;
		tile_full = TPW'(my * mw) + TPW'(mx);
		hit = ({1'b0, col_q} < w_q) && ({1'b0, row_q} < h_q)
			&& ({1'b0, mx} < mw) && ({1'b0, my} < mh)
			&& (tile_full < TPW'(MAX_TILES));
	end

	// ---- raster counters, wrap at line and frame end ----
	assign col_inc = {1'b0, col_q} + (CW + 1)'(1);
	assign row_inc = {1'b0, row_q} + (RW + 1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc_pix) begin
			if (col_inc >= w_q) begin
				col_q <= '0;
				if (row_inc >= h_q)
					row_q <= '0;
				else
					row_q <= row_inc[RW-1:0];
			end else begin
				col_q <= col_inc[CW-1:0];
			end
		end
	end

	// ---- direction map: load writes, pixel reads ----
	always_ff @(posedge clk) begin
		if (acc_load && (int'(pixels.map_index) < MAX_TILES))
			dir_mem[TW'(pixels.map_index)] <= pixels.direction;
	end

	always_ff @(posedge clk) begin
		if (en_s1)
			dir_s1 <= dir_mem[TW'(tile_full)];
	end

	// ---- stage 1 ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en_s1)
			v_s1 <= acc_pix && hit;
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			pix_s1 <= pixels.pixel;
			dx_s1  <= OW'(col_q) & smask;
			dy_s1  <= OW'(row_q) & smask;
			tx_s1  <= col_q & ~CW'(smask);
			ty_s1  <= row_q & ~RW'(smask);
		end
	end

	// rotate the in-tile offset; S-1-d equals d xor the mask
	always_comb begin
		case (dir_t'(dir_s1))
			DIR_RIGHT: begin
				ox = dy_s1;
				oy = dx_s1 ^ smask;
			end
			DIR_DOWN: begin
				ox = dx_s1 ^ smask;
				oy = dy_s1 ^ smask;
			end
			DIR_LEFT: begin
				ox = dy_s1 ^ smask;
				oy = dx_s1;
			end
			default: begin
				ox = dx_s1;
				oy = dy_s1;
			end
		endcase
	end

	// ---- stage 2 ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (en_s2)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			pix_s2 <= pix_s1;
			col_s2 <= tx_s1 + CW'(ox);
			row_s2 <= ty_s1 + RW'(oy);
		end
	end

	// ---- output register: row * width + column ----
	assign addr_sum = PW'(row_s2 * w_q) + PW'(col_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if (en_out)
			out_v_q <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			addr_q <= ADDR_W'(addr_sum);
			pix_q  <= pix_s2;
		end
	end

	assign results.valid        = out_v_q;
	assign results.dest_address = addr_q;
	assign results.pixel_value  = pix_q;

	// ---- assertions ----
	// a load beat never turns into a result
	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		acc_load |=> !v_s1)
		else $error("load beat entered the result pipeline");

	// input stalls only when every stage holds a pixel
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!pixels.ready |-> (v_s1 && v_s2 && out_v_q))
		else $error("input stalled with a free stage");

	// rotated position stays inside the frame
	a_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (({1'b0, col_s2} < w_q) && ({1'b0, row_s2} < h_q)))
		else $error("rotated pixel outside the frame");

	// map read data holds while stage 1 is stalled
	a_map_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !en_s1) |=> $stable(dir_s1))
		else $error("map read data changed during stall");

endmodule
`default_nettype wire

[tb/tb_tile_rotation_pixel_remap_unit.sv]
// ----------------------------------------------------------------------------
// tb_tile_rotation_pixel_remap_unit
// Self-checking bench for the tile rotation pixel remap unit. A short table of
// directed beats comes first, then randomized phases over many frame and tile
// sizes. A tile-rotation predictor in the bench works out each remapped
// address; result beats are checked in order against it or a typed address.
// ----------------------------------------------------------------------------
module tb_tile_rotation_pixel_remap_unit;
	import trpr_pkg::*;

	localparam int MAX_W    = MAX_WIDTH_DEF;
	localparam int MAX_T    = MAX_TILES_DEF;
	localparam int MAX_CUBE = TILE_LOG2_MAX_DEF;
	localparam int SETTLE   = 16;    // cycles to let the pipeline empty

	typedef enum logic [1:0] {
		CHK_PREDICT,   // expectation from the predictor
		CHK_SILENT,    // typed: no result beat
		CHK_TYPED      // typed: result at row address
	} chk_kind_t;

	typedef enum logic [1:0] {
		IDLE_NONE,
		IDLE_SEND,
		IDLE_RECV,
		IDLE_BOTH
	} idle_mode_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  dest_address;
		logic [PIXEL_W-1:0] pixel_value;
	} remap_t;

	typedef struct packed {
		logic [FUNC_W-1:0]    func;
		logic [MAP_IDX_W-1:0] map_index;
		dir_t                 direction;
		logic [PIXEL_W-1:0]   pixel;
		chk_kind_t            kind;
		logic [ADDR_W-1:0]    addr;
	} stim_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	trpr_in_if  pixels ();
	trpr_out_if results ();

	tile_rotation_pixel_remap_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.pixels    (pixels),
		.results   (results)
	);

	// directed beats; reset geometry is 16x16 tiles on a 640x480 frame
	stim_row_t directed_rows [0:15] = '{
		'{FUNC_LOAD,  14'h0000, DIR_UP,    32'hFFFF_FFFF, CHK_SILENT,  22'd0},
		'{FUNC_PIXEL, 14'h0000, DIR_UP,    32'h0000_0000, CHK_TYPED,   22'd0},
		'{FUNC_PIXEL, 14'h3FFF, DIR_LEFT,  32'hFFFF_FFFF, CHK_TYPED,   22'd1},
		'{FUNC_LOAD,  14'h0000, DIR_RIGHT, 32'h0000_0000, CHK_SILENT,  22'd0},
		'{FUNC_PIXEL, 14'h0000, DIR_UP,    32'hAAAA_AAAA, CHK_PREDICT, 22'd0},
		'{FUNC_LOAD,  14'h0000, DIR_DOWN,  32'h0000_0000, CHK_SILENT,  22'd0},
		'{FUNC_PIXEL, 14'h2AAA, DIR_RIGHT, 32'h5555_5555, CHK_PREDICT, 22'd0},
		'{FUNC_LOAD,  14'h0000, DIR_LEFT,  32'h0000_0000, CHK_SILENT,  22'd0},
		'{FUNC_PIXEL, 14'h1555, DIR_DOWN,  32'h0123_4567, CHK_PREDICT, 22'd0},
		'{FUNC_LOAD,  14'h3FFF, DIR_LEFT,  32'h0000_0000, CHK_SILENT,  22'd0},
		'{FUNC_LOAD,  14'h2AAA, DIR_RIGHT, 32'hFFFF_FFFF, CHK_SILENT,  22'd0},
		'{FUNC_LOAD,  14'h1555, DIR_DOWN,  32'h0000_0000, CHK_SILENT,  22'd0},
		'{FUNC_LOAD,  14'h0000, DIR_UP,    32'h0000_0000, CHK_SILENT,  22'd0},
		'{FUNC_PIXEL, 14'h0000, DIR_UP,    32'hDEAD_BEEF, CHK_TYPED,   22'd5},
		'{FUNC_PIXEL, 14'h0000, DIR_UP,    32'h8000_0000, CHK_TYPED,   22'd6},
		'{FUNC_PIXEL, 14'h0000, DIR_UP,    32'h0000_0001, CHK_TYPED,   22'd7}
	};

	// predictor state
	logic [CUBE_W-1:0] cube_cfg;
	logic [DIM_W-1:0]  width_cfg;
	logic [DIM_W-1:0]  height_cfg;
	int                col_q;
	int                row_q;
	dir_t              dir_map    [MAX_T];
	bit                map_loaded [MAX_T];

	remap_t     remap_q [$];
	int         mismatches;
	int         send_gap_pct;
	int         recv_stall_pct;
	chk_kind_t  row_kind;
	logic [ADDR_W-1:0] row_addr;

	// clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// effective geometry after saturation of the registers
	function automatic void geom(output int cb, output int w, output int h);
		cb = (cube_cfg > MAX_CUBE) ? MAX_CUBE : int'(cube_cfg);
		w  = (width_cfg == 0) ? 1 : ((width_cfg > MAX_W) ? MAX_W : int'(width_cfg));
		h  = (height_cfg == 0) ? 1 :
			((height_cfg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_cfg));
	endfunction

	// tile of the pixel at (col,row); 1 when it lies in a whole, mapped tile
	function automatic bit locate_tile(input int col, input int row, output int tile);
		int cb, w, h, mx, my, mw, mh;
		geom(cb, w, h);
		mx = col >> cb;
		my = row >> cb;
		mw = w >> cb;
		mh = h >> cb;
		tile = my * mw + mx;
		return col < w && row < h && mx < mw && my < mh && tile < MAX_T;
	endfunction

	function automatic int active_tiles();
		int cb, w, h, n;
		geom(cb, w, h);
		n = (w >> cb) * (h >> cb);
		return (n > MAX_T) ? MAX_T : n;
	endfunction

	// apply one accepted beat; returns 1 with the remapped pixel when one is due
	function automatic bit remap_beat(input logic func, input logic [MAP_IDX_W-1:0] idx,
			input dir_t dir, input logic [PIXEL_W-1:0] value, output remap_t res);
		int cb, w, h, side, tile, dx, dy, ox, oy, base;
		bit hit;
		res = '0;
		if (func == FUNC_LOAD) begin
			dir_map[idx]    = dir;
			map_loaded[idx] = 1'b1;
			return 1'b0;
		end
		geom(cb, w, h);
		hit = locate_tile(col_q, row_q, tile);
		if (hit) begin
			side = 1 << cb;
			dx   = col_q & (side - 1);
			dy   = row_q & (side - 1);
			case (dir_map[tile])
				DIR_RIGHT: begin
					ox = dy;
					oy = side - 1 - dx;
				end
				DIR_DOWN: begin
					ox = side - 1 - dx;
					oy = side - 1 - dy;
				end
				DIR_LEFT: begin
					ox = side - 1 - dy;
					oy = dx;
				end
				default: begin
					ox = dx;
					oy = dy;
				end
			endcase
			base = ((row_q >> cb) << cb) * w + ((col_q >> cb) << cb);
			res.dest_address = ADDR_W'(base + oy * w + ox);
			res.pixel_value  = value;
		end
		// raster counters wrap at line and frame end
		col_q++;
		if (col_q >= w) begin
			col_q = 0;
			row_q++;
			if (row_q >= h)
				row_q = 0;
		end
		return hit;
	endfunction

	// input and output monitor
	always @(posedge clk) begin : watch
		remap_t pred;
		remap_t got;
		remap_t want;
		bit     hit;
		if (arst_n && pixels.valid && pixels.ready) begin
			hit = remap_beat(pixels.func, pixels.map_index, dir_t'(pixels.direction),
				pixels.pixel, pred);
			case (row_kind)
				CHK_TYPED:   remap_q.push_back('{row_addr, pixels.pixel});
				CHK_PREDICT: if (hit) remap_q.push_back(pred);
				default: ;
			endcase
		end
		if (arst_n && results.valid && results.ready) begin
			got = '{results.dest_address, results.pixel_value};
			if (remap_q.size() == 0) begin
				$error("dest_address: expected no beat, got %h", got.dest_address);
				mismatches++;
			end else begin
				want = remap_q.pop_front();
				if (got.dest_address !== want.dest_address) begin
					$error("dest_address: expected %h, got %h",
						want.dest_address, got.dest_address);
					mismatches++;
				end
				if (got.pixel_value !== want.pixel_value) begin
					$error("pixel_value: expected %h, got %h",
						want.pixel_value, got.pixel_value);
					mismatches++;
				end
			end
		end
	end

	// result side back-pressure
	initial begin
		results.ready = 1'b0;
		forever begin
			@(negedge clk);
			results.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
		end
	end

	task automatic set_idling(input idle_mode_t mode);
		case (mode)
			IDLE_SEND: begin
				send_gap_pct   = 53;
				recv_stall_pct = 0;
			end
			IDLE_RECV: begin
				send_gap_pct   = 0;
				recv_stall_pct = 53;
			end
			IDLE_BOTH: begin
				send_gap_pct   = 12;
				recv_stall_pct = 12;
			end
			default: begin
				send_gap_pct   = 0;
				recv_stall_pct = 0;
			end
		endcase
	endtask

	// one beat on pixels; entered and left at a falling edge
	task automatic send_beat(input logic func, input logic [MAP_IDX_W-1:0] idx,
			input dir_t dir, input logic [PIXEL_W-1:0] value, input chk_kind_t kind,
			input logic [ADDR_W-1:0] addr);
		while ($urandom_range(99, 0) < send_gap_pct) begin
			pixels.valid <= 1'b0;
			@(negedge clk);
		end
		pixels.valid     <= 1'b1;
		pixels.func      <= func;
		pixels.map_index <= idx;
		pixels.direction <= dir;
		pixels.pixel     <= value;
		row_kind         <= kind;
		row_addr         <= addr;
		@(posedge clk);
		while (!pixels.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// pixel beat; loads the tile's direction first when it was never written
	task automatic send_pixel(input logic [PIXEL_W-1:0] value);
		int tile;
		if (locate_tile(col_q, row_q, tile) && !map_loaded[tile])
			send_beat(FUNC_LOAD, MAP_IDX_W'(tile), dir_t'($urandom_range(3, 0)),
				$urandom, CHK_PREDICT, '0);
		send_beat(FUNC_PIXEL, MAP_IDX_W'($urandom), dir_t'($urandom_range(3, 0)),
			value, CHK_PREDICT, '0);
	endtask

	// hold the sender until every expected beat is out and the pipe is empty
	task automatic drain();
		pixels.valid <= 1'b0;
		while (remap_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input int value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= CFG_DATA_W'(value);
		case (idx)
			REG_CUBE_BITS:   cube_cfg   = CUBE_W'(value);
			REG_FRAME_WIDTH: width_cfg  = DIM_W'(value);
			default:         height_cfg = DIM_W'(value);
		endcase
		@(negedge clk);
	endtask

	task automatic configure(input int cube, input int w, input int h);
		write_reg(REG_CUBE_BITS, cube);
		write_reg(REG_FRAME_WIDTH, w);
		write_reg(REG_FRAME_HEIGHT, h);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// random mix of map loads and pixels
	task automatic run_random(input int count);
		int n;
		logic [MAP_IDX_W-1:0] idx;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99, 0) < 12) begin
				n = active_tiles();
				if (n > 0 && $urandom_range(9, 0) < 7)
					idx = MAP_IDX_W'($urandom_range(n - 1, 0));
				else
					idx = MAP_IDX_W'($urandom);
				send_beat(FUNC_LOAD, idx, dir_t'($urandom_range(3, 0)), $urandom,
					CHK_PREDICT, '0);
			end else begin
				send_pixel($urandom);
			end
		end
	endtask

	// main sequence
	initial begin
		int cube, w, h;
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = REG_CUBE_BITS;
		cfg_wdata        = '0;
		pixels.valid     = 1'b0;
		pixels.func      = FUNC_LOAD;
		pixels.map_index = '0;
		pixels.direction = DIR_UP;
		pixels.pixel     = '0;
		row_kind         = CHK_PREDICT;
		row_addr         = '0;
		mismatches       = 0;
		cube_cfg         = CUBE_W'(CUBE_BITS_RST);
		width_cfg        = DIM_W'(FRAME_WIDTH_RST);
		height_cfg       = DIM_W'(FRAME_HEIGHT_RST);
		col_q            = 0;
		row_q            = 0;
		set_idling(IDLE_NONE);
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table, reset geometry
		foreach (directed_rows[i])
			send_beat(directed_rows[i].func, directed_rows[i].map_index,
				directed_rows[i].direction, directed_rows[i].pixel,
				directed_rows[i].kind, directed_rows[i].addr);
		drain();

		// walk the row counter to 8 on a one-pixel-wide frame, then widen it
		// so that every tile number is at or past the map depth
		configure(0, 1, MAX_HEIGHT);
		set_idling(IDLE_BOTH);
		repeat (8) send_pixel($urandom);
		drain();
		configure(0, MAX_W, MAX_HEIGHT);
		repeat (40) send_pixel($urandom);
		drain();

		// random phases; first ones sit on the register extremes
		for (int p = 0; p < 18; p++) begin
			case (p)
				0: begin cube = MAX_CUBE; w = MAX_W; h = MAX_HEIGHT; end
				1: begin cube = 7; w = 4095; h = 4095; end
				2: begin cube = 0; w = 0; h = 0; end
				3: begin
					cube = CUBE_BITS_RST;
					w    = FRAME_WIDTH_RST;
					h    = FRAME_HEIGHT_RST;
				end
				4: begin cube = 6; w = 33; h = 17; end
				default: begin
					cube = ($urandom_range(4, 0) == 0) ? $urandom_range(7, 0) :
						$urandom_range(3, 0);
					w = $urandom_range(40, 1);
					h = $urandom_range(40, 1);
				end
			endcase
			configure(cube, w, h);
			set_idling(idle_mode_t'(p % 4));
			run_random(100);
			drain();
		end

		if (mismatches == 0 && remap_q.size() == 0)
			$display("tile_rotation_pixel_remap_unit verification clean");
		else
			$display("tile_rotation_pixel_remap_unit verification failed");
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("tile_rotation_pixel_remap_unit verification failed");
		$finish;
	end

endmodule
